// ===== design/kmer_viterbi_local_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the k-mer Viterbi decoder
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef KMER_VITERBI_LOCAL_DECODER_TOP_DEFINES_SVH
`define KMER_VITERBI_LOCAL_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Plain invariant, checked at every clock edge outside reset.
`define KVD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kvd assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define KVD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kvd assertion failed");
`else
`define KVD_ASSERT(lbl, prop)
`define KVD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== design/kvd_pkg.sv =====
// ----------------------------------------------------------------------------
// kvd_pkg
// Sizes, codes and types shared by the k-mer Viterbi decoder.
// ----------------------------------------------------------------------------
package kvd_pkg;

  localparam int NBASE      = 4;
  localparam int NSTATES    = 256;
  localparam int MAX_BLOCKS = 512;

  localparam int NST       = NSTATES + 2;
  localparam int ST_START  = NSTATES;
  localparam int ST_END    = NSTATES + 1;
  localparam int STEP_REM  = NSTATES / NBASE;
  localparam int SKIP_COLS = NBASE * NBASE;
  localparam int SKIP_REM  = NSTATES / SKIP_COLS;

  localparam int SCW      = 32;
  localparam int DW       = 18;
  localparam int PW       = 10;
  localparam int SW       = $clog2(NST);
  localparam int WPW      = $clog2(NSTATES + 1);
  localparam int BW       = $clog2(MAX_BLOCKS + 1);
  localparam int PLW      = $clog2(MAX_BLOCKS + 2);
  localparam int SAW      = $clog2(2 * NST);
  localparam int TB_DEPTH = MAX_BLOCKS * NST;
  localparam int TB_AW    = $clog2(TB_DEPTH);
  localparam int PAW      = $clog2(MAX_BLOCKS + 1);
  localparam int STEP_AW  = $clog2(STEP_REM);
  localparam int SKIP_AW  = $clog2(SKIP_REM);
  localparam int STEP_CW  = $clog2(NBASE);
  localparam int SKIP_CW  = $clog2(SKIP_COLS);
  localparam int CNTW     = $clog2(((NST > MAX_BLOCKS) ? NST : MAX_BLOCKS) + 1);
  localparam int UW       = 3;

  localparam logic signed [SCW-1:0] SCORE_MINF = {1'b1, {(SCW-1){1'b0}}};
  localparam logic signed [SCW-1:0] SCORE_MAX  = {1'b0, {(SCW-1){1'b1}}};
  localparam logic signed [PW-1:0]  PATH_STAY  = '1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_BAD    = 2'd3
  } kvd_cmd_e;

  typedef enum logic [1:0] {
    KIND_SCORE = 2'd0,
    KIND_PATH  = 2'd1,
    KIND_ERR   = 2'd2
  } kvd_kind_e;

  typedef enum logic [1:0] {
    REG_STAY  = 2'd0,
    REG_SKIP  = 2'd1,
    REG_LOCAL = 2'd2
  } kvd_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEPCOL,
    S_SKIPCOL,
    S_ENDMAX,
    S_UPD,
    S_ARGMAX,
    S_PCLR,
    S_TRACE,
    S_LEAD,
    S_TRAIL,
    S_PREAD,
    S_RESULT
  } kvd_state_e;

  function automatic logic signed [DW-1:0] ext16(input logic signed [15:0] x);
    return {{(DW-16){x[15]}}, x};
  endfunction

endpackage

// ===== design/kvd_sat_add.sv =====
// ----------------------------------------------------------------------------
// kvd_sat_add
// Shared saturating score adder; minus infinity absorbs any delta.
// ----------------------------------------------------------------------------
module kvd_sat_add import kvd_pkg::*; (
  input  logic signed [SCW-1:0] s_i,
  input  logic signed [DW-1:0]  d_i,
  output logic signed [SCW-1:0] r_o
);

  logic [SCW:0] sum;

  assign sum = {s_i[SCW-1], s_i} + {{(SCW+1-DW){d_i[DW-1]}}, d_i};

  always_comb begin
    if (s_i == SCORE_MINF) begin
      r_o = SCORE_MINF;
    end else if (sum[SCW] != sum[SCW-1]) begin
      // Overflow high clamps to the maximum, low falls to minus infinity.
      r_o = sum[SCW] ? SCORE_MINF : SCORE_MAX;
    end else begin
      r_o = sum[SCW-1:0];
    end
  end

endmodule

// ===== design/kmer_viterbi_local_decoder_top.sv =====
// ----------------------------------------------------------------------------
// kmer_viterbi_local_decoder_top
// Viterbi decoder over k-mer states with local start and end states.
// ----------------------------------------------------------------------------
// Items enter one at a time and the block is busy until each is done. In a state
// weight update one score memory read port and one saturating adder serve the
// step, skip, stay and start-exit candidates in turn. The stay weight that opens
// a block runs two column-max scans over the previous scores and one end-state
// scan, all through the same read port. A finish runs the argmax, path clear,
// traceback and the start/end relabeling. No clearing pass follows reset: a flag
// stands in for the reset values of the scores until the first block has
// rewritten them all.
`include "kmer_viterbi_local_decoder_top_defines.svh"

module kmer_viterbi_local_decoder_top import kvd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic signed [15:0]   weight_i,
  input  logic [9:0]           path_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           kind_o,
  output logic signed [31:0]   score_o,
  output logic signed [9:0]    path_state_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  kvd_state_e state_q, state_d;

  // Configuration.
  logic signed [15:0] stay_p_q, skip_p_q, local_p_q;

  // Control and datapath registers.
  logic [WPW-1:0]        wpos_q;
  logic [BW-1:0]         blk_q;
  logic                  bank_q;
  logic                  init_q;
  logic signed [15:0]    stay_w_q;
  logic signed [15:0]    w_q;
  logic [9:0]            idx_q;
  logic [CNTW-1:0]       cnt_q;
  logic [CNTW-1:0]       tag_q;
  logic                  tvld_q;
  logic [UW-1:0]         u_q;
  logic signed [SCW-1:0] v_q;
  logic signed [PW-1:0]  tb_q;
  logic [SKIP_CW-1:0]    bestc_q;
  logic [SW-1:0]         last_q;
  logic                  path_valid_q;
  logic [PLW-1:0]        path_len_q;
  logic [1:0]            res_kind_q;
  logic signed [SCW-1:0] res_score_q;
  logic signed [PW-1:0]  res_path_q;
  logic                  out_valid_q;
  logic [1:0]            out_kind_q;
  logic signed [SCW-1:0] out_score_q;
  logic signed [PW-1:0]  out_path_q;

  // Memories and their registered read data.
  logic signed [SCW-1:0] score_mem [2*NST];
  logic signed [SCW-1:0] srd_q;
  logic [STEP_CW-1:0]    step_mem [STEP_REM];
  logic [SKIP_CW-1:0]    skip_mem [SKIP_REM];
  logic [STEP_CW-1:0]    step_rd_q;
  logic [SKIP_CW-1:0]    skip_rd_q;
  logic signed [PW-1:0]  tb_mem [TB_DEPTH];
  logic signed [PW-1:0]  tbrd_q;
  logic signed [PW-1:0]  path_mem [MAX_BLOCKS+1];
  logic signed [PW-1:0]  prd_q;

  // Memory controls.
  logic                  srd_en, srd_bank, swe;
  logic [SW-1:0]         srd_st, sw_st;
  logic signed [SCW-1:0] sw_val;
  logic [SAW-1:0]        srd_addr, sw_addr;
  logic                  colrd_en, stepwe, skipwe;
  logic [STEP_CW-1:0]    stepw_val;
  logic [SKIP_CW-1:0]    skipw_val;
  logic [STEP_AW-1:0]    stepw_addr;
  logic [SKIP_AW-1:0]    skipw_addr;
  logic                  tbwe, tbrd_en;
  logic [SW-1:0]         tbw_st;
  logic signed [PW-1:0]  tbw_val;
  logic [TB_AW-1:0]      tbw_addr, tbr_addr;
  logic                  pwe, prd_en;
  logic [PAW-1:0]        pw_addr, prd_addr;
  logic signed [PW-1:0]  pw_val;

  // Shared adder.
  logic signed [SCW-1:0] add_s, add_r;
  logic signed [DW-1:0]  add_d;

  // Derived values.
  logic signed [DW-1:0]  neg_lp, neg_skip, stay_d, loc_d, w_d;
  logic [SW-1:0]         hst, step_h, skip_h;
  logic [STEP_AW-1:0]    sp;
  logic [SKIP_AW-1:0]    kp;
  logic [SKIP_CW-1:0]    col_c, col_nc;
  logic                  col_last;
  logic [CNTW-1:0]       scan_n;
  logic                  scan_done;
  logic                  in_acc, out_free, read_ok;
  logic [BW-1:0]         ri;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign neg_lp   = -ext16(local_p_q);
  assign neg_skip = -ext16(skip_p_q);
  assign stay_d   = ext16(stay_w_q) - ext16(stay_p_q);
  assign loc_d    = (neg_lp > stay_d) ? neg_lp : stay_d;
  assign w_d      = ext16(w_q);

  // Current state of a weight update and its step and skip predecessors.
  assign hst    = SW'(wpos_q - WPW'(1));
  assign sp     = STEP_AW'(hst / NBASE);
  assign kp     = SKIP_AW'(hst / SKIP_COLS);
  assign step_h = SW'(int'(sp) + int'(step_rd_q) * STEP_REM);
  assign skip_h = SW'(int'(kp) + int'(skip_rd_q) * SKIP_REM);
  assign ri     = blk_q - BW'(cnt_q) - BW'(1);

  assign read_ok = path_valid_q && (int'(path_index_i) < int'(path_len_q)) &&
                   (int'(path_index_i) <= MAX_BLOCKS);

  assign scan_done = (cnt_q == scan_n) && !tvld_q;

  kvd_sat_add u_add (
    .s_i (add_s),
    .d_i (add_d),
    .r_o (add_r)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kvd_cmd_e'(cmd_i))
            CMD_LOAD: begin
              if (wpos_q != '0) begin
                state_d = S_UPD;
              end else if (blk_q >= BW'(MAX_BLOCKS)) begin
                state_d = S_RESULT;
              end else begin
                state_d = S_STEPCOL;
              end
            end
            CMD_FINISH: state_d = (wpos_q != '0) ? S_RESULT : S_ARGMAX;
            CMD_READ:   state_d = read_ok ? S_PREAD : S_RESULT;
            CMD_BAD:    state_d = S_RESULT;
          endcase
        end
      end
      S_STEPCOL: if (scan_done) state_d = S_SKIPCOL;
      S_SKIPCOL: if (scan_done) state_d = S_ENDMAX;
      S_ENDMAX:  if (scan_done) state_d = S_IDLE;
      S_UPD:     if (u_q == UW'(6)) state_d = S_IDLE;
      S_ARGMAX:  if (scan_done) state_d = S_PCLR;
      S_PCLR:    if (cnt_q == CNTW'(blk_q)) state_d = S_TRACE;
      S_TRACE:   if (u_q == '0 && cnt_q == CNTW'(blk_q)) state_d = S_LEAD;
      S_LEAD: begin
        if (u_q == '0 && cnt_q == CNTW'(blk_q)) begin
          state_d = S_TRAIL;
        end else if (u_q == UW'(1) && prd_q != PW'(ST_START)) begin
          state_d = S_TRAIL;
        end
      end
      S_TRAIL: begin
        if (u_q == UW'(1) && (prd_q != PW'(ST_END) || cnt_q == '0)) begin
          state_d = S_RESULT;
        end
      end
      S_PREAD:  if (u_q == UW'(1)) state_d = S_RESULT;
      S_RESULT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Memory controls and shared adder operands.
  always_comb begin
    srd_en     = 1'b0;
    srd_bank   = ~bank_q;
    srd_st     = '0;
    swe        = 1'b0;
    sw_st      = '0;
    sw_val     = v_q;
    colrd_en   = 1'b0;
    stepwe     = 1'b0;
    skipwe     = 1'b0;
    stepw_addr = STEP_AW'(tag_q / NBASE);
    skipw_addr = SKIP_AW'(tag_q / SKIP_COLS);
    stepw_val  = STEP_CW'(col_nc);
    skipw_val  = col_nc;
    tbwe       = 1'b0;
    tbw_st     = '0;
    tbw_val    = tb_q;
    tbrd_en    = 1'b0;
    pwe        = 1'b0;
    pw_addr    = PAW'(cnt_q);
    pw_val     = PATH_STAY;
    prd_en     = 1'b0;
    prd_addr   = PAW'(cnt_q);
    add_s      = srd_q;
    add_d      = w_d;
    scan_n     = CNTW'(NST);
    col_c      = '0;
    col_last   = 1'b0;
    unique case (state_q)
      S_STEPCOL: begin
        scan_n   = CNTW'(NSTATES);
        srd_en   = (cnt_q < scan_n);
        srd_st   = SW'(int'(cnt_q) % NBASE * STEP_REM + int'(cnt_q) / NBASE);
        col_c    = SKIP_CW'(int'(tag_q) % NBASE);
        col_last = (int'(col_c) == NBASE - 1);
        stepwe   = tvld_q && col_last;
      end
      S_SKIPCOL: begin
        scan_n   = CNTW'(NSTATES);
        srd_en   = (cnt_q < scan_n);
        srd_st   = SW'(int'(cnt_q) % SKIP_COLS * SKIP_REM + int'(cnt_q) / SKIP_COLS);
        col_c    = SKIP_CW'(int'(tag_q) % SKIP_COLS);
        col_last = (int'(col_c) == SKIP_COLS - 1);
        skipwe   = tvld_q && col_last;
      end
      S_ENDMAX: begin
        srd_en = (cnt_q < scan_n);
        if (cnt_q == '0) begin
          srd_st = SW'(ST_START);
        end else if (cnt_q == CNTW'(1)) begin
          srd_st = SW'(ST_END);
        end else begin
          srd_st = SW'(cnt_q - CNTW'(2));
        end
        add_d = (tag_q < CNTW'(2)) ? loc_d : neg_lp;
        if (tvld_q && tag_q == '0) begin
          // The start state only stays.
          swe     = 1'b1;
          sw_st   = SW'(ST_START);
          sw_val  = add_r;
          tbwe    = 1'b1;
          tbw_st  = SW'(ST_START);
          tbw_val = PW'(ST_START);
        end else if (scan_done) begin
          swe    = 1'b1;
          sw_st  = SW'(ST_END);
          tbwe   = 1'b1;
          tbw_st = SW'(ST_END);
        end
      end
      S_UPD: begin
        unique case (u_q)
          UW'(0): colrd_en = 1'b1;
          UW'(1): begin
            srd_en = 1'b1;
            srd_st = step_h;
          end
          UW'(2): begin
            srd_en = 1'b1;
            srd_st = skip_h;
          end
          UW'(3): begin
            srd_en = 1'b1;
            srd_st = hst;
            add_d  = neg_skip;
          end
          UW'(4): add_s = v_q;
          UW'(5): begin
            srd_en = 1'b1;
            srd_st = SW'(ST_START);
            add_d  = stay_d;
          end
          UW'(6): begin
            swe    = 1'b1;
            sw_st  = hst;
            sw_val = (add_r > v_q) ? add_r : v_q;
            tbwe   = 1'b1;
            tbw_st = hst;
            tbw_val = (add_r > v_q) ? PW'(ST_START) : tb_q;
          end
          default: ;
        endcase
      end
      S_ARGMAX: begin
        srd_en   = (cnt_q < scan_n);
        srd_bank = bank_q;
        srd_st   = SW'(cnt_q);
      end
      S_PCLR: pwe = 1'b1;
      S_TRACE: begin
        if (u_q == '0 && cnt_q == CNTW'(blk_q)) begin
          pwe     = 1'b1;
          pw_addr = '0;
          pw_val  = PW'(last_q);
        end else if (u_q == '0) begin
          tbrd_en = 1'b1;
        end else if (!tbrd_q[PW-1]) begin
          pwe     = 1'b1;
          pw_addr = PAW'(ri + BW'(1));
          pw_val  = PW'(last_q);
        end
      end
      S_LEAD: begin
        prd_en = (u_q == '0) && (cnt_q != CNTW'(blk_q));
        pwe    = (u_q == UW'(1)) && (prd_q == PW'(ST_START));
      end
      S_TRAIL: begin
        prd_en = (u_q == '0);
        pwe    = (u_q == UW'(1)) && (prd_q == PW'(ST_END));
      end
      S_PREAD: begin
        prd_en   = (u_q == '0);
        prd_addr = PAW'(idx_q);
      end
      default: ;
    endcase
    // Column argmax keeps the first column on ties.
    col_nc = (col_c == '0 || srd_q > v_q) ? col_c : bestc_q;
  end

  assign srd_addr = srd_bank ? SAW'(int'(srd_st) + NST) : SAW'(srd_st);
  assign sw_addr  = bank_q ? SAW'(int'(sw_st) + NST) : SAW'(sw_st);
  assign tbw_addr = TB_AW'(int'(blk_q) * NST + int'(tbw_st));
  assign tbr_addr = TB_AW'(int'(ri) * NST + int'(last_q));

  // Score memory. While the init flag is set the scores read as their reset
  // values: start at zero, everything else at minus infinity.
  always_ff @(posedge clk_i) begin
    if (swe) score_mem[sw_addr] <= sw_val;
    if (srd_en) begin
      if (init_q) begin
        srd_q <= (srd_st == SW'(ST_START)) ? '0 : SCORE_MINF;
      end else begin
        srd_q <= score_mem[srd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stepwe) step_mem[stepw_addr] <= stepw_val;
    if (skipwe) skip_mem[skipw_addr] <= skipw_val;
    if (colrd_en) begin
      step_rd_q <= step_mem[sp];
      skip_rd_q <= skip_mem[kp];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbwe) tb_mem[tbw_addr] <= tbw_val;
    if (tbrd_en) tbrd_q <= tb_mem[tbr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pwe) path_mem[pw_addr] <= pw_val;
    if (prd_en) prd_q <= path_mem[prd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stay_p_q  <= '0;
      skip_p_q  <= '0;
      local_p_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STAY:  stay_p_q  <= cfg_data_i;
        REG_SKIP:  skip_p_q  <= cfg_data_i;
        REG_LOCAL: local_p_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      wpos_q       <= '0;
      blk_q        <= '0;
      bank_q       <= 1'b0;
      init_q       <= 1'b1;
      stay_w_q     <= '0;
      w_q          <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      tag_q        <= '0;
      tvld_q       <= 1'b0;
      u_q          <= '0;
      v_q          <= SCORE_MINF;
      tb_q         <= '0;
      bestc_q      <= '0;
      last_q       <= '0;
      path_valid_q <= 1'b0;
      path_len_q   <= '0;
      res_kind_q   <= KIND_ERR;
      res_score_q  <= '0;
      res_path_q   <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_ERR;
      out_score_q  <= '0;
      out_path_q   <= '0;
    end else begin
      state_q <= state_d;
      tvld_q  <= srd_en;
      tag_q   <= cnt_q;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            w_q         <= weight_i;
            idx_q       <= path_index_i;
            res_kind_q  <= KIND_ERR;
            res_score_q <= '0;
            res_path_q  <= '0;
            if (kvd_cmd_e'(cmd_i) == CMD_LOAD && wpos_q == '0 &&
                blk_q < BW'(MAX_BLOCKS)) begin
              // Block start: the old current bank becomes the previous one.
              bank_q   <= ~bank_q;
              stay_w_q <= weight_i;
              wpos_q   <= WPW'(1);
            end
          end
        end
        S_STEPCOL, S_SKIPCOL: begin
          if (srd_en) cnt_q <= cnt_q + CNTW'(1);
          if (tvld_q) begin
            bestc_q <= col_nc;
            if (col_c == '0 || srd_q > v_q) v_q <= srd_q;
          end
        end
        S_ENDMAX: begin
          if (srd_en) cnt_q <= cnt_q + CNTW'(1);
          if (tvld_q && tag_q == CNTW'(1)) begin
            v_q  <= add_r;
            tb_q <= PW'(ST_END);
          end else if (tvld_q && tag_q >= CNTW'(2) && add_r > v_q) begin
            v_q  <= add_r;
            tb_q <= PW'(tag_q - CNTW'(2));
          end
        end
        S_UPD: begin
          u_q <= u_q + UW'(1);
          unique case (u_q)
            UW'(2): begin
              v_q  <= srd_q;
              tb_q <= PW'(step_h);
            end
            UW'(3): begin
              // Skip wins ties against step.
              if (!(v_q > add_r)) begin
                v_q  <= add_r;
                tb_q <= PW'(skip_h);
              end
            end
            UW'(4): v_q <= add_r;
            UW'(5): begin
              if (add_r > v_q) begin
                v_q  <= add_r;
                tb_q <= PATH_STAY;
              end
            end
            UW'(6): begin
              if (wpos_q == WPW'(NSTATES)) begin
                wpos_q <= '0;
                blk_q  <= blk_q + BW'(1);
                init_q <= 1'b0;
              end else begin
                wpos_q <= wpos_q + WPW'(1);
              end
            end
            default: ;
          endcase
        end
        S_ARGMAX: begin
          if (srd_en) cnt_q <= cnt_q + CNTW'(1);
          if (tvld_q && (tag_q == '0 || srd_q > v_q)) begin
            v_q    <= srd_q;
            last_q <= SW'(tag_q);
          end
          if (scan_done) res_score_q <= v_q;
        end
        S_PCLR: cnt_q <= cnt_q + CNTW'(1);
        S_TRACE: begin
          if (u_q == '0) begin
            u_q <= UW'(1);
          end else begin
            u_q   <= '0;
            cnt_q <= cnt_q + CNTW'(1);
            if (!tbrd_q[PW-1]) last_q <= SW'(tbrd_q);
          end
        end
        S_LEAD: begin
          if (u_q == '0) begin
            u_q <= UW'(1);
          end else begin
            u_q   <= '0;
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        S_TRAIL: begin
          if (u_q == '0) begin
            u_q <= UW'(1);
          end else begin
            u_q   <= '0;
            cnt_q <= cnt_q - CNTW'(1);
            if (state_d == S_RESULT) begin
              // Chunk done: keep the path, return the scores to reset.
              path_len_q   <= PLW'(blk_q) + PLW'(1);
              path_valid_q <= 1'b1;
              res_kind_q   <= KIND_SCORE;
              blk_q        <= '0;
              wpos_q       <= '0;
              stay_w_q     <= '0;
              init_q       <= 1'b1;
            end
          end
        end
        S_PREAD: begin
          u_q <= UW'(1);
          if (u_q == UW'(1)) begin
            res_kind_q <= KIND_PATH;
            res_path_q <= prd_q;
          end
        end
        default: ;
      endcase

      // Entry into a new state restarts its counters.
      if (state_d != state_q) begin
        cnt_q  <= (state_d == S_TRAIL) ? CNTW'(blk_q) : '0;
        u_q    <= '0;
        tvld_q <= 1'b0;
      end

      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
        out_kind_q  <= res_kind_q;
        out_score_q <= res_score_q;
        out_path_q  <= res_path_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign score_o      = out_score_q;
  assign path_state_o = out_path_q;

  `KVD_ASSERT(a_wpos_range, wpos_q <= WPW'(NSTATES))
  `KVD_ASSERT(a_blk_range, blk_q <= BW'(MAX_BLOCKS))
  `KVD_ASSERT_NXT(a_full_error, in_acc && cmd_i == CMD_LOAD && wpos_q == '0 && blk_q >= BW'(MAX_BLOCKS), state_q == S_RESULT && res_kind_q == KIND_ERR)
  `KVD_ASSERT_NXT(a_finish_reinit, state_q == S_TRAIL && state_d == S_RESULT, init_q && blk_q == '0 && path_valid_q && res_kind_q == KIND_SCORE)

endmodule

// ===== sim/tb_kmer_viterbi_local_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the k-mer Viterbi decoder
// Drives weight, finish and path read items through the valid/stall input
// channel, predicts every result with an independent cycle-free model of the
// decoder and compares each result item field by field as it leaves.
// ----------------------------------------------------------------------------
module tb_kmer_viterbi_local_decoder_top;
  import kvd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point minus infinity and the largest score.
  localparam int SC_MINF = -2147483648;
  localparam int SC_MAX  = 2147483647;
  // Cycles that cover the slowest item the block can still be working on.
  localparam int DRAIN_CYCLES = 1200;

  typedef struct {
    kvd_kind_e   kind;
    logic [31:0] score;
    logic [9:0]  path_state;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_LOAD;
  logic signed [15:0] weight_i = '0;
  logic [9:0]  path_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic signed [31:0] score_o;
  logic signed [9:0]  path_state_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = REG_STAY;
  logic [15:0] cfg_data_i = '0;

  kmer_viterbi_local_decoder_top u_top (.*);

  always #2 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Decoder state as the predictor sees it.
  // -------------------------------------------------------------------------
  int      score_now [NST];
  int      score_prev [NST];
  int      step_col [STEP_REM];
  int      skip_col [SKIP_REM];
  shortint trace_mem [MAX_BLOCKS][NST];
  shortint path_mem [MAX_BLOCKS+1];
  int      nblocks;
  int      wpos;
  longint  stay_weight;
  bit      path_ok;
  int      path_count;
  longint  pen_stay, pen_skip, pen_local;

  result_t expected_results[$];
  int      n_errors = 0;
  bit      idle_on = 1'b1;
  int      stall_left = 0;

  function automatic int sat_add(int s, longint d);
    longint r;
    if (s == SC_MINF) return SC_MINF;
    r = longint'(s) + d;
    if (r > SC_MAX) return SC_MAX;
    if (r < SC_MINF) return SC_MINF;
    return int'(r);
  endfunction

  function automatic void clear_scores();
    foreach (score_now[i]) score_now[i] = SC_MINF;
    score_now[ST_START] = 0;
    nblocks = 0;
    wpos = 0;
    stay_weight = 0;
  endfunction

  // Stay weight opens a block: column maxima, start/end states.
  function automatic void open_block(longint w);
    longint stay_d, loc_d;
    int s;
    stay_d = w - pen_stay;
    loc_d = (-pen_local > stay_d) ? -pen_local : stay_d;
    stay_weight = w;
    score_prev = score_now;
    foreach (step_col[r]) step_col[r] = 0;
    for (int c = 1; c < NBASE; c++)
      for (int r = 0; r < STEP_REM; r++)
        if (score_prev[c*STEP_REM+r] > score_prev[step_col[r]*STEP_REM+r]) step_col[r] = c;
    foreach (skip_col[r]) skip_col[r] = 0;
    for (int c = 1; c < SKIP_COLS; c++)
      for (int r = 0; r < SKIP_REM; r++)
        if (score_prev[c*SKIP_REM+r] > score_prev[skip_col[r]*SKIP_REM+r]) skip_col[r] = c;
    score_now[ST_START] = sat_add(score_prev[ST_START], loc_d);
    trace_mem[nblocks][ST_START] = ST_START;
    score_now[ST_END] = sat_add(score_prev[ST_END], loc_d);
    trace_mem[nblocks][ST_END] = ST_END;
    for (int h = 0; h < NSTATES; h++) begin
      s = sat_add(score_prev[h], -pen_local);
      if (s > score_now[ST_END]) begin
        score_now[ST_END] = s;
        trace_mem[nblocks][ST_END] = h;
      end
    end
  endfunction

  function automatic void update_state(int h, longint w);
    int sp, kp, step_h, skip_h, a, b, v, s;
    shortint tb;
    sp = h / NBASE;
    kp = h / SKIP_COLS;
    step_h = (sp + step_col[sp] * STEP_REM) % NST;
    skip_h = (kp + skip_col[kp] * SKIP_REM) % NST;
    a = score_prev[step_h];
    b = sat_add(score_prev[skip_h], -pen_skip);
    if (a > b) begin
      v = a;
      tb = step_h;
    end else begin
      v = b;
      tb = skip_h;
    end
    v = sat_add(v, w);
    s = sat_add(score_prev[h], stay_weight - pen_stay);
    if (s > v) begin
      v = s;
      tb = -1;
    end
    s = sat_add(score_prev[ST_START], w);
    if (s > v) begin
      v = s;
      tb = ST_START;
    end
    score_now[h] = v;
    trace_mem[nblocks][h] = tb;
  endfunction

  // Argmax, traceback and relabeling of leading start / trailing end.
  function automatic int trace_path();
    int last, best, ri;
    shortint s;
    last = 0;
    for (int i = 1; i < NST; i++)
      if (score_now[i] > score_now[last]) last = i;
    best = score_now[last];
    for (int i = 0; i <= nblocks; i++) path_mem[i] = -1;
    for (int i = 0; i < nblocks; i++) begin
      ri = nblocks - i - 1;
      s = trace_mem[ri][last];
      if (s >= 0) begin
        path_mem[ri+1] = last;
        last = s % NST;
      end
    end
    path_mem[0] = last;
    for (int i = 0; i < nblocks; i++) begin
      if (path_mem[i] == ST_START) path_mem[i] = -1;
      else break;
    end
    for (int i = nblocks + 1; i > 0; i--) begin
      if (path_mem[i-1] == ST_END) path_mem[i-1] = -1;
      else break;
    end
    path_count = nblocks + 1;
    path_ok = 1'b1;
    return best;
  endfunction

  // Applies one accepted item to the predictor and queues its result, if any.
  function automatic void predict_item(kvd_cmd_e cmd, logic signed [15:0] w, int idx);
    result_t res;
    res.kind = KIND_ERR;
    res.score = '0;
    res.path_state = '0;
    case (cmd)
      CMD_LOAD: begin
        if (wpos == 0) begin
          if (nblocks >= MAX_BLOCKS) begin
            expected_results.push_back(res);
            return;
          end
          open_block(w);
          wpos = 1;
        end else begin
          update_state(wpos - 1, w);
          wpos++;
          if (wpos > NSTATES) begin
            wpos = 0;
            nblocks++;
          end
        end
        return;
      end
      CMD_FINISH: begin
        if (wpos == 0) begin
          res.kind = KIND_SCORE;
          res.score = trace_path();
          clear_scores();
        end
      end
      CMD_READ: begin
        if (path_ok && idx < path_count && idx <= MAX_BLOCKS) begin
          res.kind = KIND_PATH;
          res.path_state = path_mem[idx][9:0];
        end
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers.
  // -------------------------------------------------------------------------
  task automatic send_item(kvd_cmd_e cmd, logic signed [15:0] w, logic [9:0] idx);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    weight_i <= w;
    path_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(cmd, w, idx);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits until every expected result has come and the block has settled.
  task automatic wait_idle();
    end_burst();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(kvd_reg_e r, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      REG_STAY:  pen_stay  = longint'($signed(val));
      REG_SKIP:  pen_skip  = longint'($signed(val));
      default:   pen_local = longint'($signed(val));
    endcase
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return $urandom();
      default: return 16'(-$signed($urandom_range(0, 3072)));
    endcase
  endfunction

  task automatic send_block(bit noisy);
    for (int i = 0; i <= NSTATES; i++) begin
      // Occasional stray items inside a block: reads, unknown commands and
      // finishes, which must all answer without disturbing the block.
      if (noisy && $urandom_range(0, 31) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(CMD_READ, $urandom(), $urandom());
          1: send_item(CMD_BAD, $urandom(), $urandom());
          default: if (i != 0) send_item(CMD_FINISH, $urandom(), $urandom());
        endcase
      end
      send_item(CMD_LOAD, pick_value(), $urandom());
    end
  endtask

  task automatic read_path(int extra);
    for (int i = 0; i < path_count + extra; i++) send_item(CMD_READ, $urandom(), i);
  endtask

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------

  // Fresh block: reads before any finish, unknown command, empty finish, reads after it.
  task automatic test_empty_chunk();
    send_item(CMD_READ, 16'h0000, 10'd0);
    send_item(CMD_BAD, 16'hffff, 10'h3ff);
    send_item(CMD_FINISH, 16'h1234, 10'd0);
    send_item(CMD_READ, 16'h0000, 10'd0);
    send_item(CMD_READ, 16'h0000, 10'd1);
    send_item(CMD_READ, 16'h0000, 10'h3ff);
    wait_idle();
  endtask

  // Extreme penalties and weights, plus a finish inside an open block.
  task automatic test_extremes();
    write_reg(REG_STAY, 16'h8000);
    write_reg(REG_SKIP, 16'h7fff);
    write_reg(REG_LOCAL, 16'h8000);
    send_item(CMD_LOAD, 16'h7fff, 10'd0);
    send_item(CMD_LOAD, 16'h8000, 10'd0);
    send_item(CMD_FINISH, 16'h0000, 10'd0);
    for (int i = 2; i <= NSTATES; i++)
      send_item(CMD_LOAD, (i % 2) ? 16'h7fff : 16'h8000, 10'd0);
    send_item(CMD_FINISH, 16'h0000, 10'd0);
    read_path(2);
    wait_idle();
  endtask

  // Random penalties and chunks of at most one block with random content.
  task automatic test_random_chunks();
    for (int p = 0; p < 6; p++) begin
      idle_on = (p % 3) != 2;
      write_reg(REG_STAY, pick_value());
      write_reg(REG_SKIP, pick_value());
      write_reg(REG_LOCAL, pick_value());
      repeat ($urandom_range(0, 1)) send_block(1'b1);
      send_item(CMD_FINISH, $urandom(), $urandom());
      read_path($urandom_range(0, 2));
      send_item(CMD_READ, $urandom(), $urandom());
      wait_idle();
    end
  endtask

  // Fills every block, then one load with no room, a finish, reads at and past the top index and random reads.
  task automatic test_full_chunk();
    idle_on = 1'b0;
    write_reg(REG_STAY, 16'h0100);
    write_reg(REG_SKIP, 16'h0400);
    write_reg(REG_LOCAL, 16'h0200);
    for (int b = 0; b < MAX_BLOCKS; b++) send_block(1'b0);
    send_item(CMD_LOAD, $urandom(), 10'd0);
    send_item(CMD_FINISH, 16'h0000, 10'd0);
    idle_on = 1'b1;
    send_item(CMD_READ, 16'h0000, 10'(MAX_BLOCKS));
    send_item(CMD_READ, 16'h0000, 10'(MAX_BLOCKS + 1));
    send_item(CMD_READ, 16'h0000, 10'h3ff);
    for (int i = 0; i < 20; i++)
      send_item(CMD_READ, 16'h0000, $urandom_range(0, MAX_BLOCKS));
    wait_idle();
  endtask

  // Result stall: a random hold-off drawn for each result item.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_left <= idle_on ? $urandom_range(0, 16) : 0;
      if (expected_results.size() == 0) begin
        $error("result item with none expected: kind %0d", kind_o);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          n_errors++;
        end
        if (score_o !== want.score) begin
          $error("score: expected %0d, got %0d", $signed(want.score), score_o);
          n_errors++;
        end
        if (path_state_o !== want.path_state) begin
          $error("path_state: expected %0d, got %0d", $signed(want.path_state),
                 path_state_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    pen_stay = 0;
    pen_skip = 0;
    pen_local = 0;
    path_ok = 1'b0;
    path_count = 0;
    clear_scores();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_chunk();
    test_extremes();
    test_random_chunks();
    test_full_chunk();
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Overall limit, well above the slowest correct run.
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
